>>> src/aem_pkg.sv
// Shared constants and types for the antialiased ellipse mask combine block.
// Used by the top level and its testbench; the divider and square root pipelines do not use it.
package aem_pkg;

	localparam int PIXEL_BITS     = 13;
	localparam int MASK_BITS      = 8;
	localparam int CFG_IDX_BITS   = 3;
	localparam int COORD_BITS_DEF = 14;
	localparam int FRAC_BITS_DEF  = 24;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_RECT_LEFT   = 3'd0,
		CFG_RECT_TOP    = 3'd1,
		CFG_RECT_WIDTH  = 3'd2,
		CFG_RECT_HEIGHT = 3'd3,
		CFG_COMBINE     = 3'd4,
		CFG_ANTI_ALIAS  = 3'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MODE_REPLACE = 2'd0,
		MODE_MAX     = 2'd1,
		MODE_SUB     = 2'd2,
		MODE_MIN     = 2'd3
	} comb_mode_t;

endpackage

>>> src/antialiased_ellipse_mask_combine_top.sv
// Ellipse coverage rasterizer with mask combine: top level, configuration and pipeline.
// Depends on aem_pkg, aem_div and aem_sqrt.
//
// One pixel per clock is accepted and one result per clock is delivered while the output is not
// stalled. Each pixel passes through three bit-serial pipelines in series: the normalizing
// dividers (FRAC_BITS+2 stages), the gradient square root (FRAC_BITS+3 stages) and the
// distance divider (FRAC_BITS stages). A stall on the output holds the whole pipeline; no
// request is dropped or repeated. Configuration registers must only be written while the
// pipeline holds no request.
module antialiased_ellipse_mask_combine_top #(
	parameter int COORD_BITS = aem_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = aem_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [aem_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [COORD_BITS-1:0]              cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [aem_pkg::PIXEL_BITS-1:0]     pixel_x,
	input  logic [aem_pkg::PIXEL_BITS-1:0]     pixel_y,
	input  logic [aem_pkg::MASK_BITS-1:0]      old_value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [aem_pkg::MASK_BITS-1:0]      new_value,
	output logic [aem_pkg::MASK_BITS-1:0]      coverage
);

	localparam int C    = COORD_BITS;
	localparam int F    = FRAC_BITS;
	localparam int PB   = aem_pkg::PIXEL_BITS;
	localparam int MB   = aem_pkg::MASK_BITS;
	localparam int DW   = ((C > PB) ? C : PB) + 3;
	localparam int UW   = F + 2;
	localparam int NU_W = C + F + 2;
	localparam int NP_W = C + F + 3;
	localparam int AA_W = 2 * C;
	localparam int SQ_W = 2 * F + 6;
	localparam int RT_W = F + 3;
	localparam int G_W  = F + 4;
	localparam int D_W  = F + 5;
	localparam int NF_W = 2 * F + 4;
	localparam int S1_W = MB + 1;
	localparam int S2_W = MB + 1 + D_W;
	localparam int S3_W = MB + 3;

	// configuration
	logic signed [C-1:0]  rect_left_q;
	logic signed [C-1:0]  rect_top_q;
	logic [C-1:0]         rect_width_q;
	logic [C-1:0]         rect_height_q;
	aem_pkg::comb_mode_t  combine_mode_q;
	logic                 anti_alias_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rect_left_q    <= '0;
			rect_top_q     <= '0;
			rect_width_q   <= C'(3);
			rect_height_q  <= C'(3);
			combine_mode_q <= aem_pkg::MODE_REPLACE;
			anti_alias_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				aem_pkg::CFG_RECT_LEFT:   rect_left_q    <= cfg_data;
				aem_pkg::CFG_RECT_TOP:    rect_top_q     <= cfg_data;
				aem_pkg::CFG_RECT_WIDTH:  rect_width_q   <= cfg_data;
				aem_pkg::CFG_RECT_HEIGHT: rect_height_q  <= cfg_data;
				aem_pkg::CFG_COMBINE:     combine_mode_q <= aem_pkg::comb_mode_t'(cfg_data[1:0]);
				aem_pkg::CFG_ANTI_ALIAS:  anti_alias_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic en;
	logic out_vld_q;
	assign en       = !out_vld_q || !out_stall;
	assign in_stall = !en;

	// s1: input capture
	logic          vld_s1;
	logic [PB-1:0] x_s1, y_s1;
	logic [MB-1:0] old_s1;

	// s2: window test and offsets
	logic signed [DW-1:0] dx, dy, wx, hy, xx, yy;
	logic                 out_win, thin;
	logic [C-1:0]         a_w, b_h;
	logic                 vld_s2, zero_s2;
	logic [MB-1:0]        old_s2;
	logic [C:0]           ax_s2, ay_s2;
	logic [C-1:0]         a_s2, b_s2;
	logic [AA_W-1:0]      aa_s2, bb_s2;

	assign dx  = $signed(DW'(x_s1)) - DW'(rect_left_q);
	assign dy  = $signed(DW'(y_s1)) - DW'(rect_top_q);
	assign wx  = $signed(DW'(rect_width_q));
	assign hy  = $signed(DW'(rect_height_q));
	assign out_win = (dx[DW-1] && (dx != '1)) || (!dx[DW-1] && (dx > wx))
		|| (dy[DW-1] && (dy != '1)) || (!dy[DW-1] && (dy > hy));
	assign thin = (rect_width_q < C'(3)) || (rect_height_q < C'(3));
	assign a_w  = rect_width_q - C'(1);
	assign b_h  = rect_height_q - C'(1);
	assign xx   = (dx <<< 1) - $signed(DW'(a_w));
	assign yy   = (dy <<< 1) - $signed(DW'(b_h));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= pixel_x;
			y_s1    <= pixel_y;
			old_s1  <= old_value;
			zero_s2 <= out_win || thin;
			old_s2  <= old_s1;
			ax_s2   <= (C+1)'(xx[DW-1] ? -xx : xx);
			ay_s2   <= (C+1)'(yy[DW-1] ? -yy : yy);
			a_s2    <= a_w;
			b_s2    <= b_h;
			aa_s2   <= AA_W'(a_w) * AA_W'(a_w);
			bb_s2   <= AA_W'(b_h) * AA_W'(b_h);
		end
	end

	// normalized offsets and gradient halves
	logic            u_vld, v_vld, p_vld, q_vld;
	logic [UW-1:0]   u_quo, v_quo, p_quo, q_quo;
	logic [S1_W-1:0] u_side;

	aem_div #(.NUM_W(NU_W), .DEN_W(C), .Q_W(UW), .SIDE_W(S1_W)) u_div_u (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s2),
		.num((NU_W'(ax_s2) << F) + NU_W'(a_s2 >> 1)), .den(a_s2),
		.side({zero_s2, old_s2}),
		.out_vld(u_vld), .quo(u_quo), .side_out(u_side)
	);

	aem_div #(.NUM_W(NU_W), .DEN_W(C), .Q_W(UW), .SIDE_W(1)) u_div_v (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s2),
		.num((NU_W'(ay_s2) << F) + NU_W'(b_s2 >> 1)), .den(b_s2),
		.side(1'b0),
		.out_vld(v_vld), .quo(v_quo), .side_out()
	);

	aem_div #(.NUM_W(NP_W), .DEN_W(AA_W), .Q_W(UW), .SIDE_W(1)) u_div_p (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s2),
		.num((NP_W'(ax_s2) << (F + 1)) + NP_W'(aa_s2 >> 1)), .den(aa_s2),
		.side(1'b0),
		.out_vld(p_vld), .quo(p_quo), .side_out()
	);

	aem_div #(.NUM_W(NP_W), .DEN_W(AA_W), .Q_W(UW), .SIDE_W(1)) u_div_q (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s2),
		.num((NP_W'(ay_s2) << (F + 1)) + NP_W'(bb_s2 >> 1)), .den(bb_s2),
		.side(1'b0),
		.out_vld(q_vld), .quo(q_quo), .side_out()
	);

	// s3: squares, s4: sums
	logic              vld_s3, vld_s4;
	logic [2*UW-1:0]   uu_s3, vv_s3, pp_s3, qq_s3;
	logic [S1_W-1:0]   side_s3, side_s4;
	logic [2*UW:0]     dsum;
	logic [D_W-1:0]    d_s4;
	logic [SQ_W-1:0]   pq_s4;

	assign dsum = (2*UW+1)'(uu_s3) + (2*UW+1)'(vv_s3) + ((2*UW+1)'(1) << (F - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s3 <= u_vld;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			uu_s3   <= (2*UW)'(u_quo) * (2*UW)'(u_quo);
			vv_s3   <= (2*UW)'(v_quo) * (2*UW)'(v_quo);
			pp_s3   <= (2*UW)'(p_quo) * (2*UW)'(p_quo);
			qq_s3   <= (2*UW)'(q_quo) * (2*UW)'(q_quo);
			side_s3 <= u_side;
			d_s4    <= D_W'(dsum >> F);
			pq_s4   <= SQ_W'(pp_s3) + SQ_W'(qq_s3);
			side_s4 <= side_s3;
		end
	end

	// gradient magnitude
	logic            rt_vld;
	logic [RT_W-1:0] rt;
	logic [S2_W-1:0] rt_side;

	aem_sqrt #(.V_W(SQ_W), .SIDE_W(S2_W)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s4),
		.val(pq_s4), .side({side_s4, d_s4}),
		.out_vld(rt_vld), .root(rt), .side_out(rt_side)
	);

	// s5: distance numerator and saturation
	logic [D_W-1:0]  d5, nmag;
	logic [G_W-1:0]  g;
	logic            le5, sat5;
	logic            vld_s5;
	logic [NF_W-1:0] num_s5;
	logic [G_W-1:0]  g_s5;
	logic [S3_W-1:0] side_s5;

	assign d5   = rt_side[D_W-1:0];
	assign g    = (rt == '0) ? G_W'(1) : {rt, 1'b0};
	assign le5  = d5 <= (D_W'(1) << F);
	assign nmag = le5 ? (D_W'(1) << F) - d5 : d5 - (D_W'(1) << F);
	assign sat5 = nmag >= D_W'(g);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= rt_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s5  <= sat5 ? '0 : {nmag[F+3:0], F'(0)};
			g_s5    <= g;
			side_s5 <= {rt_side[S2_W-1:D_W], le5, sat5};
		end
	end

	logic            fd_vld;
	logic [F-1:0]    fd_quo;
	logic [S3_W-1:0] fd_side;

	aem_div #(.NUM_W(NF_W), .DEN_W(G_W), .Q_W(F), .SIDE_W(S3_W)) u_div_dist (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s5),
		.num(num_s5), .den(g_s5), .side(side_s5),
		.out_vld(fd_vld), .quo(fd_quo), .side_out(fd_side)
	);

	// s6: clamped band value, s7: coverage byte
	logic [F:0]      half, one, c6;
	logic            le6, sat6, zero6;
	logic            vld_s6, vld_s7;
	logic [F:0]      c_s6;
	logic            le_s6, zero_s6;
	logic [MB-1:0]   old_s6, old_s7, cov_s7;
	logic [F+8:0]    scaled;
	logic [MB-1:0]   cov7;

	assign half  = (F+1)'(1) << (F - 1);
	assign one   = (F+1)'(1) << F;
	assign le6   = fd_side[1];
	assign sat6  = fd_side[0];
	assign zero6 = fd_side[S3_W-1];

	always_comb begin
		if (le6) begin
			c6 = (sat6 || ((F+1)'(fd_quo) >= half)) ? one : (F+1)'(fd_quo) + half;
		end else begin
			c6 = (sat6 || ((F+1)'(fd_quo) >= half)) ? '0 : half - (F+1)'(fd_quo);
		end
	end

	assign scaled = ((F+9)'(c_s6) << 8) - (F+9)'(c_s6) + (F+9)'(half);
	assign cov7   = zero_s6 ? '0 :
		anti_alias_q ? scaled[F+7:F] : (le_s6 ? '1 : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s6 <= fd_vld;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s6    <= c6;
			le_s6   <= le6;
			zero_s6 <= zero6;
			old_s6  <= fd_side[S3_W-2:2];
			cov_s7  <= cov7;
			old_s7  <= old_s6;
		end
	end

	// output register with combine
	logic [MB-1:0] comb;
	logic [MB-1:0] new_value_q, coverage_q;

	always_comb begin
		case (combine_mode_q)
			aem_pkg::MODE_REPLACE: comb = cov_s7;
			aem_pkg::MODE_MAX:     comb = (old_s7 > cov_s7) ? old_s7 : cov_s7;
			aem_pkg::MODE_SUB:     comb = (old_s7 > cov_s7) ? old_s7 - cov_s7 : '0;
			default:               comb = (old_s7 < cov_s7) ? old_s7 : cov_s7;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			new_value_q <= comb;
			coverage_q  <= cov_s7;
		end
	end

	assign out_valid = out_vld_q;
	assign new_value = new_value_q;
	assign coverage  = coverage_q;

	// the four normalizing dividers run in lockstep
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(u_vld == v_vld) && (u_vld == p_vld) && (u_vld == q_vld))
		else $error("normalizing dividers out of step");

	a_hard_edge: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !anti_alias_q |-> (coverage == '0) || (coverage == '1))
		else $error("hard edge coverage not 0 or 255");

	a_max_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && (combine_mode_q == aem_pkg::MODE_MAX) |-> new_value >= coverage)
		else $error("max combine below coverage");

endmodule

>>> src/aem_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Needs num < den << Q_W. No package dependency.
module aem_div #(
	parameter int NUM_W  = 40,
	parameter int DEN_W  = 14,
	parameter int Q_W    = 26,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side,
	output logic              out_vld,
	output logic [Q_W-1:0]    quo,
	output logic [SIDE_W-1:0] side_out
);

	logic              vld_s  [1:Q_W];
	logic [DEN_W-1:0]  hi_s   [1:Q_W];
	logic [Q_W-1:0]    lo_s   [1:Q_W];
	logic [DEN_W-1:0]  den_s  [1:Q_W];
	logic [SIDE_W-1:0] side_s [1:Q_W];

	for (genvar k = 0; k < Q_W; k++) begin : g_step
		logic              src_vld;
		logic [DEN_W-1:0]  src_hi;
		logic [Q_W-1:0]    src_lo;
		logic [DEN_W-1:0]  src_den;
		logic [SIDE_W-1:0] src_side;
		logic [DEN_W:0]    trial;
		logic [DEN_W:0]    diff;
		logic              ge;

		if (k == 0) begin : g_first
			assign src_vld  = in_vld;
			assign src_hi   = DEN_W'(num >> Q_W);
			assign src_lo   = num[Q_W-1:0];
			assign src_den  = den;
			assign src_side = side;
		end else begin : g_next
			assign src_vld  = vld_s[k];
			assign src_hi   = hi_s[k];
			assign src_lo   = lo_s[k];
			assign src_den  = den_s[k];
			assign src_side = side_s[k];
		end

		assign trial = {src_hi, src_lo[Q_W-1]};
		assign ge    = trial >= {1'b0, src_den};
		assign diff  = trial - {1'b0, src_den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				hi_s[k+1]   <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				lo_s[k+1]   <= {src_lo[Q_W-2:0], ge};
				den_s[k+1]  <= src_den;
				side_s[k+1] <= src_side;
			end
		end
	end

	assign out_vld  = vld_s[Q_W];
	assign quo      = lo_s[Q_W];
	assign side_out = side_s[Q_W];

endmodule

>>> src/aem_sqrt.sv
// Pipelined integer square root, one root bit per stage, with sideband.
// Root is floor(sqrt(val)). No package dependency.
module aem_sqrt #(
	parameter int V_W    = 54,
	parameter int SIDE_W = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  logic [V_W-1:0]     val,
	input  logic [SIDE_W-1:0]  side,
	output logic               out_vld,
	output logic [V_W/2-1:0]   root,
	output logic [SIDE_W-1:0]  side_out
);

	localparam int N   = V_W / 2;
	localparam int R_W = N + 2;

	logic              vld_s  [1:N];
	logic [R_W-1:0]    rem_s  [1:N];
	logic [V_W-1:0]    val_s  [1:N];
	logic [N-1:0]      root_s [1:N];
	logic [SIDE_W-1:0] side_s [1:N];

	for (genvar k = 0; k < N; k++) begin : g_step
		logic              src_vld;
		logic [R_W-1:0]    src_rem;
		logic [V_W-1:0]    src_val;
		logic [N-1:0]      src_root;
		logic [SIDE_W-1:0] src_side;
		logic [R_W+1:0]    t;
		logic [R_W+1:0]    trial;
		logic [R_W+1:0]    diff;
		logic              ge;

		if (k == 0) begin : g_first
			assign src_vld  = in_vld;
			assign src_rem  = '0;
			assign src_val  = val;
			assign src_root = '0;
			assign src_side = side;
		end else begin : g_next
			assign src_vld  = vld_s[k];
			assign src_rem  = rem_s[k];
			assign src_val  = val_s[k];
			assign src_root = root_s[k];
			assign src_side = side_s[k];
		end

		assign t     = {src_rem, src_val[V_W-1 -: 2]};
		assign trial = {R_W'(src_root), 2'b01};
		assign ge    = t >= trial;
		assign diff  = t - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? diff[R_W-1:0] : t[R_W-1:0];
				val_s[k+1]  <= src_val << 2;
				root_s[k+1] <= {src_root[N-2:0], ge};
				side_s[k+1] <= src_side;
			end
		end
	end

	assign out_vld  = vld_s[N];
	assign root     = root_s[N];
	assign side_out = side_s[N];

endmodule

>>> test/tb_antialiased_ellipse_mask_combine_top.sv
// Self-checking testbench for antialiased_ellipse_mask_combine_top: random and directed pixels
// are predicted by a fixed-point ellipse coverage model and checked on the result channel.
// Depends on aem_pkg and the block's RTL.
module tb_antialiased_ellipse_mask_combine_top;

	typedef struct packed {
		logic [aem_pkg::PIXEL_BITS-1:0] x;
		logic [aem_pkg::PIXEL_BITS-1:0] y;
		logic [aem_pkg::MASK_BITS-1:0]  old;
	} pixel_req_t;

	typedef struct packed {
		logic [aem_pkg::MASK_BITS-1:0] mask;
		logic [aem_pkg::MASK_BITS-1:0] cov;
	} mask_res_t;

	localparam int FB         = aem_pkg::FRAC_BITS_DEF;
	localparam int CB         = aem_pkg::COORD_BITS_DEF;
	localparam int PIPE_WAIT  = 3 * FB + 40;
	localparam int STUCK_MAX  = 5000;

	logic                             clk = 0;
	logic                             arst_n = 0;
	logic                             cfg_we = 0;
	logic [aem_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CB-1:0]                    cfg_data = '0;
	logic                             in_valid = 0;
	logic                             in_stall;
	logic [aem_pkg::PIXEL_BITS-1:0]   pixel_x = '0;
	logic [aem_pkg::PIXEL_BITS-1:0]   pixel_y = '0;
	logic [aem_pkg::MASK_BITS-1:0]    old_value = '0;
	logic                             out_valid;
	logic                             out_stall = 0;
	logic [aem_pkg::MASK_BITS-1:0]    new_value;
	logic [aem_pkg::MASK_BITS-1:0]    coverage;

	antialiased_ellipse_mask_combine_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.pixel_x(pixel_x), .pixel_y(pixel_y), .old_value(old_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.new_value(new_value), .coverage(coverage)
	);

	always #6 clk = ~clk;

	pixel_req_t pending_pixels[$];
	mask_res_t  expected_masks[$];
	int         mismatches = 0;
	bit         calm = 0;
	bit         hold_req = 0;
	int         hold_left = 0;
	bit         in_taken = 0;
	int         stuck_cycles = 0;

	longint              m_left = 0, m_top = 0, m_width = 3, m_height = 3;
	aem_pkg::comb_mode_t m_mode = aem_pkg::MODE_REPLACE;
	bit                  m_aa = 0;

	function automatic longint unsigned floor_root(longint unsigned v);
		longint unsigned r, t;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= v)
				r = t;
		end
		return r;
	endfunction

	function automatic logic [7:0] ellipse_cov(longint x, longint y);
		longint unsigned one, half, ax, ay, ua, ub, u, v, d, p, q, g, nmag, quo;
		longint a, b, ox, oy, band;
		one = 64'd1 << FB;
		half = 64'd1 << (FB - 1);
		if (m_width < 3 || m_height < 3)
			return 0;
		if (x < m_left - 1 || x > m_left + m_width || y < m_top - 1 || y > m_top + m_height)
			return 0;
		a = m_width - 1;
		b = m_height - 1;
		ox = 2 * x - 2 * m_left - a;
		oy = 2 * y - 2 * m_top - b;
		ax = ox < 0 ? -ox : ox;
		ay = oy < 0 ? -oy : oy;
		ua = a;
		ub = b;
		u = ((ax << FB) + ua / 2) / ua;
		v = ((ay << FB) + ub / 2) / ub;
		d = (u * u + v * v + half) >> FB;
		if (!m_aa)
			return d <= one ? 8'd255 : 8'd0;
		p = (((2 * ax) << FB) + (ua * ua) / 2) / (ua * ua);
		q = (((2 * ay) << FB) + (ub * ub) / 2) / (ub * ub);
		g = 2 * floor_root(p * p + q * q);
		if (g == 0)
			g = 1;
		nmag = d <= one ? one - d : d - one;
		quo = (nmag << FB) / g;
		band = d <= one ? longint'(quo) : -longint'(quo);
		band = band + longint'(half);
		if (band < 0)
			band = 0;
		if (band > longint'(one))
			band = one;
		return (longint'(band) * 255 + half) >> FB;
	endfunction

	function automatic mask_res_t combine_pixel(pixel_req_t r);
		mask_res_t e;
		e.cov = ellipse_cov(r.x, r.y);
		case (m_mode)
			aem_pkg::MODE_REPLACE: e.mask = e.cov;
			aem_pkg::MODE_MAX:     e.mask = r.old > e.cov ? r.old : e.cov;
			aem_pkg::MODE_SUB:     e.mask = r.old > e.cov ? r.old - e.cov : 8'd0;
			default:               e.mask = r.old < e.cov ? r.old : e.cov;
		endcase
		return e;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d want %0d", what, got, want);
		mismatches++;
	endtask

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 0;
		end else if (!(in_valid && !in_taken)) begin
			if (pending_pixels.size() > 0 && (calm || $urandom_range(99) >= 10)) begin
				in_valid <= 1;
				pixel_x <= pending_pixels[0].x;
				pixel_y <= pending_pixels[0].y;
				old_value <= pending_pixels[0].old;
			end else begin
				in_valid <= 0;
			end
		end
	end

	always @(posedge clk) begin
		in_taken <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall)
			expected_masks.insert(expected_masks.size(),
				combine_pixel(pending_pixels.pop_front()));
	end

	// result side: stall and check
	always @(negedge clk) begin
		if (hold_req && hold_left == 0) begin
			hold_left = 400;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1;
		end else begin
			out_stall <= !calm && $urandom_range(99) < 10;
		end
	end

	always @(posedge clk) begin
		mask_res_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_masks.size() == 0) begin
				report_mismatch("unexpected result, coverage", coverage, -1);
			end else begin
				e = expected_masks.pop_front();
				if (coverage !== e.cov)
					report_mismatch("coverage", coverage, e.cov);
				if (new_value !== e.mask)
					report_mismatch("new_value", new_value, e.mask);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles > STUCK_MAX) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic write_reg(aem_pkg::cfg_idx_t idx, longint val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val[CB-1:0];
		case (idx)
			aem_pkg::CFG_RECT_LEFT:   m_left = longint'(signed'(val[CB-1:0]));
			aem_pkg::CFG_RECT_TOP:    m_top = longint'(signed'(val[CB-1:0]));
			aem_pkg::CFG_RECT_WIDTH:  m_width = val[CB-1:0];
			aem_pkg::CFG_RECT_HEIGHT: m_height = val[CB-1:0];
			aem_pkg::CFG_COMBINE:     m_mode = aem_pkg::comb_mode_t'(val[1:0]);
			default:                  m_aa = val[0];
		endcase
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic drain;
		while (pending_pixels.size() > 0 || expected_masks.size() > 0)
			@(posedge clk);
		repeat (PIPE_WAIT) @(negedge clk);
	endtask

	task automatic set_ellipse(longint l, longint t, longint w, longint h, int mode, bit aa);
		write_reg(aem_pkg::CFG_RECT_LEFT, l);
		write_reg(aem_pkg::CFG_RECT_TOP, t);
		write_reg(aem_pkg::CFG_RECT_WIDTH, w);
		write_reg(aem_pkg::CFG_RECT_HEIGHT, h);
		write_reg(aem_pkg::CFG_COMBINE, mode);
		write_reg(aem_pkg::CFG_ANTI_ALIAS, aa);
	endtask

	function automatic int near_coord(longint lo, longint span);
		longint c;
		c = lo - 1 + $urandom_range(span + 1);
		if (c < 0 || c > 8191)
			return $urandom_range(8191);
		return c;
	endfunction

	task automatic add_pixel(int x, int y, int old);
		pixel_req_t r;
		r.x = x;
		r.y = y;
		r.old = old;
		pending_pixels.insert(pending_pixels.size(), r);
	endtask

	task automatic random_phase(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) < 8)
				add_pixel(near_coord(m_left, m_width), near_coord(m_top, m_height),
					$urandom_range(255));
			else
				add_pixel($urandom_range(8191), $urandom_range(8191), $urandom_range(255));
		end
		drain();
	endtask

	initial begin
		longint w, h;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// directed: window edges, center, canvas extremes, thin rectangles
		set_ellipse(10, 20, 7, 5, aem_pkg::MODE_REPLACE, 1);
		add_pixel(13, 22, 0);
		add_pixel(9, 19, 255);
		add_pixel(17, 25, 255);
		add_pixel(8, 22, 100);
		add_pixel(18, 22, 100);
		add_pixel(13, 26, 7);
		add_pixel(10, 22, 50);
		add_pixel(16, 21, 200);
		add_pixel(0, 0, 0);
		add_pixel(8191, 8191, 255);
		drain();
		for (int m = 0; m < 4; m++) begin
			write_reg(aem_pkg::CFG_COMBINE, m);
			add_pixel(13, 22, 128);
			add_pixel(10, 20, 128);
			add_pixel(16, 24, 255);
			add_pixel(30, 22, 90);
			drain();
		end
		set_ellipse(0, 0, 2, 5, aem_pkg::MODE_MAX, 1);
		add_pixel(0, 2, 30);
		add_pixel(1, 1, 0);
		drain();
		set_ellipse(0, 0, 5, 1, aem_pkg::MODE_REPLACE, 0);
		add_pixel(2, 0, 30);
		drain();

		// random settings, extremes among them
		for (int ph = 0; ph < 13; ph++) begin
			w = $urandom_range(9) == 0 ? 8192 : $urandom_range(40, 3);
			h = $urandom_range(9) == 0 ? 8192 : $urandom_range(40, 3);
			case (ph)
				0: set_ellipse(-8192, 8191, 3, 3, aem_pkg::MODE_MAX, 1);
				1: set_ellipse(8191, -8192, 8192, 8192, aem_pkg::MODE_SUB, 0);
				2: set_ellipse(-4, -4, 8192, 8192, aem_pkg::MODE_MIN, 1);
				3: set_ellipse(8190, 8190, 3, 3, aem_pkg::MODE_REPLACE, 1);
				default: set_ellipse(longint'($urandom_range(8300)) - 100,
					longint'($urandom_range(8300)) - 100, w, h,
					$urandom_range(3), $urandom_range(1));
			endcase
			calm = (ph == 5);
			hold_req = (ph == 7);
			random_phase(110);
		end
		calm = 0;

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> files.f
src/aem_pkg.sv
src/aem_div.sv
src/aem_sqrt.sv
src/antialiased_ellipse_mask_combine_top.sv
test/tb_antialiased_ellipse_mask_combine_top.sv
